### rtl/telnet_option_negotiator_top_macros.svh
// Assertion macros for the telnet option negotiator RTL
`ifndef TELNET_OPTION_NEGOTIATOR_TOP_MACROS_SVH
`define TELNET_OPTION_NEGOTIATOR_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define TONO_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");
`define TONO_ASSERT_NR(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) else $error("assertion failed");
`else
`define TONO_ASSERT(lbl, prop)
`define TONO_ASSERT_NR(lbl, prop)
`endif
`endif

### rtl/tono_pkg.sv
// Shared types and constants of the telnet option negotiator
package tono_pkg;

    localparam int NUM_OPTIONS_DEF = 32;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_ACCEPT_MASK_IDX = 1'b0;
    localparam logic [31:0] ACCEPT_MASK_RST = 32'd9;

    localparam logic [1:0] OP_RECV  = 2'd0;
    localparam logic [1:0] OP_XMIT  = 2'd1;
    localparam logic [1:0] OP_OFFER = 2'd2;

    localparam logic CH_HOST = 1'b0;
    localparam logic CH_LINK = 1'b1;

    localparam logic [7:0] B_IAC  = 8'd255;
    localparam logic [7:0] B_DONT = 8'd254;
    localparam logic [7:0] B_DO   = 8'd253;
    localparam logic [7:0] B_WONT = 8'd252;
    localparam logic [7:0] B_WILL = 8'd251;
    localparam logic [7:0] B_SB   = 8'd250;
    localparam logic [7:0] B_SE   = 8'd240;
    localparam logic [7:0] B_CR   = 8'd13;
    localparam logic [7:0] B_LF   = 8'd10;
    localparam logic [7:0] B_NUL  = 8'd0;

    typedef struct packed {
        logic [1:0]      count;
        logic            channel;
        logic [2:0][7:0] bytes;
    } t_result;

endpackage

### rtl/tono_in_if.sv
// Input item channel of the telnet option negotiator
interface tono_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] data_byte;
    logic       suppress_data;
    logic [4:0] option_index;

    modport source (output valid, op, data_byte, suppress_data, option_index, input ready);
    modport sink (input valid, op, data_byte, suppress_data, option_index, output ready);
endinterface

### rtl/tono_out_if.sv
// Result byte channel of the telnet option negotiator
interface tono_out_if;
    logic       valid;
    logic       ready;
    logic       channel;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, channel, out_byte, last, input ready);
    modport sink (input valid, channel, out_byte, last, output ready);
endinterface

### rtl/telnet_option_negotiator_top.sv
// Telnet option negotiator top level
// Input channel i_in_chan carries one transaction per item: op (0 byte from
// the link, 1 byte to transmit, 2 offer option), data_byte, suppress_data and
// option_index. Output channel o_out_chan carries one result byte per
// transaction, tagged with channel (0 host, 1 link) and last on the final
// byte of an item. An APB port holds the accept mask at byte address 0.
// An item is processed in the cycle it is accepted; its first result byte is
// presented on the next cycle. An item that yields more than one byte holds
// the output register until its last byte is taken, so throughput is one
// item per cycle for items with at most one result byte while the
// receiver is ready; the three-entry result register is the limiting unit.
// The next item is accepted in the cycle the last byte of the previous one
// is taken. If the receiver stalls, the current byte holds and input ready
// stays low until the final byte of the item is taken.
// Synchronous reset empties the result register, returns the parser to data
// mode, clears the pending CR and option maps (wanted keeps options 0 and 3)
// and loads the accept mask with 9.
module telnet_option_negotiator_top #(
    parameter int NUM_OPTIONS = tono_pkg::NUM_OPTIONS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tono_in_if.sink                         i_in_chan,
    tono_out_if.source                      o_out_chan,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tono_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tono_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tono_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    logic              w_ready;
    logic              w_fire;
    logic [31:0]       w_accept_mask;
    tono_pkg::t_result w_result;

    assign i_in_chan.ready = w_ready;
    assign w_fire          = i_in_chan.valid && w_ready;

    tono_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_accept_mask (w_accept_mask)
    );

    tono_engine #(
        .NUM_OPTIONS (NUM_OPTIONS)
    ) u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (w_fire),
        .i_op            (i_in_chan.op),
        .i_data_byte     (i_in_chan.data_byte),
        .i_suppress_data (i_in_chan.suppress_data),
        .i_option_index  (i_in_chan.option_index),
        .i_accept_mask   (w_accept_mask),
        .o_result        (w_result)
    );

    tono_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_fire),
        .i_result (w_result),
        .o_ready  (w_ready),
        .o_chan   (o_out_chan)
    );
endmodule

### rtl/tono_cfg.sv
// APB register block holding the option accept mask
module tono_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tono_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [tono_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [tono_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready,
    output logic [31:0]                          o_accept_mask
);
    logic        w_word;
    logic [31:0] r_accept_mask;

    assign w_word        = paddr[tono_pkg::APB_ADDR_W-1];
    assign pready        = 1'b1;
    assign o_accept_mask = r_accept_mask;
    assign prdata        = (w_word == tono_pkg::REG_ACCEPT_MASK_IDX) ? r_accept_mask : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accept_mask <= tono_pkg::ACCEPT_MASK_RST;
        end else if (psel && penable && pwrite && pready
                     && w_word == tono_pkg::REG_ACCEPT_MASK_IDX) begin
            r_accept_mask <= pwdata;
        end
    end
endmodule

### rtl/tono_engine.sv
// IAC parser, transmit stuffing and option state, one item per cycle while i_fire is high
module tono_engine #(
    parameter int NUM_OPTIONS = tono_pkg::NUM_OPTIONS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [1:0]        i_op,
    input  logic [7:0]        i_data_byte,
    input  logic              i_suppress_data,
    input  logic [4:0]        i_option_index,
    input  logic [31:0]       i_accept_mask,
    output tono_pkg::t_result o_result
);
    localparam int IDX_W = $clog2(NUM_OPTIONS);
    localparam logic [8:0] NUM_OPT_W = 9'(NUM_OPTIONS);
    localparam logic [NUM_OPTIONS-1:0] WANT_RST = {{(NUM_OPTIONS-4){1'b0}}, 4'b1001};

    typedef enum logic [2:0] {P_DATA, P_IAC, P_WILL, P_WONT, P_DO, P_DONT, P_SKIP} t_pmode;

    t_pmode                 r_mode, n_mode;
    logic                   r_cr, n_cr;
    logic [NUM_OPTIONS-1:0] r_wanted, n_wanted;
    logic [NUM_OPTIONS-1:0] r_tried, n_tried;
    logic [NUM_OPTIONS-1:0] r_offered, n_offered;
    logic [NUM_OPTIONS-1:0] r_agreed, n_agreed;

    logic             w_hb, w_hbo, w_acc, w_pos, w_t, w_w, w_o, w_a, w_reply, w_nul;
    logic [IDX_W-1:0] w_ix, w_ixo;
    logic [7:0]       w_cmd, w_b;

    assign w_b   = i_data_byte;
    assign w_hb  = {1'b0, w_b} < NUM_OPT_W;
    assign w_ix  = w_b[IDX_W-1:0];
    assign w_hbo = {4'b0, i_option_index} < NUM_OPT_W;
    assign w_ixo = IDX_W'(i_option_index);
    assign w_acc = (w_b < 8'd32) && i_accept_mask[w_b[4:0]];
    assign w_nul = r_cr && (w_b != tono_pkg::B_LF);

    always_comb begin
        unique case (r_mode)
            P_WILL:  w_cmd = w_acc ? tono_pkg::B_DO : tono_pkg::B_DONT;
            P_WONT:  w_cmd = tono_pkg::B_DONT;
            P_DO:    w_cmd = w_acc ? tono_pkg::B_WILL : tono_pkg::B_WONT;
            default: w_cmd = tono_pkg::B_WONT;
        endcase
    end

    assign w_pos   = (w_cmd == tono_pkg::B_DO) || (w_cmd == tono_pkg::B_WILL);
    assign w_t     = w_hb && r_tried[w_ix];
    assign w_w     = w_hb && r_wanted[w_ix];
    assign w_o     = w_hb && w_pos;
    assign w_a     = (w_t && (w_w == w_o)) ? w_o : (w_hb && r_agreed[w_ix]);
    assign w_reply = (w_a != w_o) || !w_t;

    always_comb begin
        n_mode    = r_mode;
        n_cr      = r_cr;
        n_wanted  = r_wanted;
        n_tried   = r_tried;
        n_offered = r_offered;
        n_agreed  = r_agreed;
        o_result  = '0;
        case (i_op)
            tono_pkg::OP_RECV: begin
                o_result.channel = tono_pkg::CH_HOST;
                n_mode           = P_DATA;
                unique case (r_mode)
                    P_IAC: begin
                        if (w_b == tono_pkg::B_IAC) begin
                            if (!i_suppress_data) begin
                                o_result.count    = 2'd1;
                                o_result.bytes[0] = w_b;
                            end
                        end else if (w_b == tono_pkg::B_WILL) begin
                            n_mode = P_WILL;
                        end else if (w_b == tono_pkg::B_WONT) begin
                            n_mode = P_WONT;
                        end else if (w_b == tono_pkg::B_DO) begin
                            n_mode = P_DO;
                        end else if (w_b == tono_pkg::B_DONT) begin
                            n_mode = P_DONT;
                        end else if (w_b == tono_pkg::B_SB || w_b == tono_pkg::B_SE) begin
                            n_mode = P_SKIP;
                        end
                    end
                    P_WILL, P_WONT, P_DO, P_DONT: begin
                        if (w_hb) begin
                            n_offered[w_ix] = w_pos;
                            if (w_t && (w_w == w_o)) begin
                                n_agreed[w_ix] = w_o;
                            end
                            if (w_reply) begin
                                n_tried[w_ix]  = 1'b1;
                                n_wanted[w_ix] = w_pos;
                            end
                        end
                        if (w_reply) begin
                            o_result.channel  = tono_pkg::CH_LINK;
                            o_result.count    = 2'd3;
                            o_result.bytes[0] = tono_pkg::B_IAC;
                            o_result.bytes[1] = w_cmd;
                            o_result.bytes[2] = w_b;
                        end
                    end
                    P_SKIP: begin
                        n_mode = P_DATA;
                    end
                    default: begin
                        if (w_b == tono_pkg::B_IAC) begin
                            n_mode = P_IAC;
                        end else if (!i_suppress_data) begin
                            o_result.count    = 2'd1;
                            o_result.bytes[0] = w_b;
                        end
                    end
                endcase
            end
            tono_pkg::OP_XMIT: begin
                o_result.channel = tono_pkg::CH_LINK;
                n_cr             = (w_b == tono_pkg::B_CR);
                if (w_nul) begin
                    o_result.bytes[0] = tono_pkg::B_NUL;
                    o_result.bytes[1] = w_b;
                    o_result.bytes[2] = tono_pkg::B_IAC;
                    o_result.count    = (w_b == tono_pkg::B_IAC) ? 2'd3 : 2'd2;
                end else begin
                    o_result.bytes[0] = w_b;
                    o_result.bytes[1] = tono_pkg::B_IAC;
                    o_result.count    = (w_b == tono_pkg::B_IAC) ? 2'd2 : 2'd1;
                end
            end
            tono_pkg::OP_OFFER: begin
                o_result.channel = tono_pkg::CH_LINK;
                if (w_hbo && r_wanted[w_ixo] && !r_tried[w_ixo]) begin
                    n_tried[w_ixo]    = 1'b1;
                    o_result.count    = 2'd3;
                    o_result.bytes[0] = tono_pkg::B_IAC;
                    o_result.bytes[1] = tono_pkg::B_WILL;
                    o_result.bytes[2] = {3'b0, i_option_index};
                end
            end
            default: begin
                o_result.count = 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= P_DATA;
            r_cr      <= 1'b0;
            r_wanted  <= WANT_RST;
            r_tried   <= '0;
            r_offered <= '0;
            r_agreed  <= '0;
        end else if (i_fire) begin
            r_mode    <= n_mode;
            r_cr      <= n_cr;
            r_wanted  <= n_wanted;
            r_tried   <= n_tried;
            r_offered <= n_offered;
            r_agreed  <= n_agreed;
        end
    end
endmodule

### rtl/tono_outq.sv
// Result register that hands out up to three bytes of one item in turn
`include "telnet_option_negotiator_top_macros.svh"
module tono_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  tono_pkg::t_result i_result,
    output logic              o_ready,
    tono_out_if.source        o_chan
);
    logic [2:0][7:0] r_bytes;
    logic            r_chan;
    logic [1:0]      r_rem;
    logic [1:0]      r_pos;

    assign o_chan.valid    = (r_rem != 2'd0);
    assign o_chan.channel  = r_chan;
    assign o_chan.out_byte = r_bytes[r_pos];
    assign o_chan.last     = (r_rem == 2'd1);
    assign o_ready         = (r_rem == 2'd0) || ((r_rem == 2'd1) && o_chan.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= 2'd0;
            r_pos <= 2'd0;
        end else if (i_load) begin
            r_rem <= i_result.count;
            r_pos <= 2'd0;
        end else if (o_chan.valid && o_chan.ready) begin
            r_rem <= r_rem - 2'd1;
            r_pos <= r_pos + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_result.bytes;
            r_chan  <= i_result.channel;
        end
    end

    `TONO_ASSERT(a_pos_in_range, o_chan.valid |-> ((3'(r_pos) + 3'(r_rem)) <= 3'd3))
    `TONO_ASSERT(a_no_accept_busy, (r_rem > 2'd1) |-> !o_ready)
    `TONO_ASSERT(a_load_fresh, (i_load && i_result.count != 2'd0) |=> (r_pos == 2'd0 && o_chan.valid))
    `TONO_ASSERT_NR(a_reset_empty, !i_rst_n |=> !o_chan.valid)
endmodule

### verif/tb_telnet_option_negotiator_top.sv
// Self-checking testbench for the telnet option negotiator top level
`timescale 1ns / 1ps

module tb_telnet_option_negotiator_top;

    localparam int          NUM_OPT     = tono_pkg::NUM_OPTIONS_DEF;
    localparam int          CYCLE_LIMIT = 300000;
    localparam int          MAX_REPORTS = 10;
    localparam logic [1:0]  OP_NONE     = 2'd3;
    localparam logic [7:0]  B_AYT       = 8'd246;

    typedef enum logic [2:0] {
        PM_DATA = 3'd0,
        PM_IAC  = 3'd1,
        PM_DONT = 3'd2,
        PM_DO   = 3'd3,
        PM_WONT = 3'd4,
        PM_WILL = 3'd5,
        PM_SKIP = 3'd6
    } t_parse_mode;

    typedef struct {
        logic       channel;
        logic [7:0] out_byte;
        logic       last;
    } t_reply_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [tono_pkg::APB_ADDR_W-1:0] paddr;
    logic [tono_pkg::APB_DATA_W-1:0] pwdata;
    logic [tono_pkg::APB_DATA_W-1:0] prdata;
    logic        pready;

    tono_in_if  in_chan ();
    tono_out_if out_chan ();

    telnet_option_negotiator_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_chan  (in_chan),
        .o_out_chan (out_chan),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // negotiator state as predicted
    logic [31:0]  accept_mask;
    t_parse_mode  parse_mode;
    logic         cr_pending;
    logic [63:0]  wanted_mask;
    logic [63:0]  tried_mask;
    logic [63:0]  offered_mask;
    logic [63:0]  agreed_mask;

    t_reply_byte  expected_bytes[$];
    int           error_count = 0;
    int           cycle_count = 0;
    int           send_idle_pct = 32;
    int           recv_idle_pct = 81;

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        out_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic note_mismatch(string what, int exp_val, int act_val);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, exp_val, act_val);
    endtask

    always @(posedge i_clk) begin
        t_reply_byte head;
        if (i_rst_n && out_chan.valid && out_chan.ready) begin
            if (expected_bytes.size() == 0) begin
                note_mismatch("unexpected transaction, byte", -1, out_chan.out_byte);
            end else begin
                head = expected_bytes.pop_front();
                if (out_chan.channel !== head.channel)
                    note_mismatch("channel", head.channel, out_chan.channel);
                if (out_chan.out_byte !== head.out_byte)
                    note_mismatch("out_byte", head.out_byte, out_chan.out_byte);
                if (out_chan.last !== head.last)
                    note_mismatch("last", head.last, out_chan.last);
            end
        end
    end

    function automatic logic bit_of(logic [63:0] m, int unsigned opt);
        return (opt < NUM_OPT && opt < 64) ? m[opt] : 1'b0;
    endfunction

    function automatic logic [63:0] with_bit(logic [63:0] m, int unsigned opt, logic v);
        logic [63:0] r;
        r = m;
        if (opt < NUM_OPT && opt < 64)
            r[opt] = v;
        return r;
    endfunction

    function automatic void emit_byte(logic ch, logic [7:0] b);
        expected_bytes.push_back('{ch, b, 1'b0});
    endfunction

    function automatic logic is_accepted(logic [7:0] opt);
        return (opt < 32) && accept_mask[opt[4:0]];
    endfunction

    function automatic void negotiate(logic [7:0] cmd, logic [7:0] opt);
        logic positive;
        logic t, w, o, a;
        positive = (cmd == tono_pkg::B_DO) || (cmd == tono_pkg::B_WILL);
        offered_mask = with_bit(offered_mask, opt, positive);
        t = bit_of(tried_mask, opt);
        w = bit_of(wanted_mask, opt);
        o = bit_of(offered_mask, opt);
        if (t && w == o)
            agreed_mask = with_bit(agreed_mask, opt, o);
        a = bit_of(agreed_mask, opt);
        if (a != o || !t) begin
            tried_mask  = with_bit(tried_mask, opt, 1'b1);
            wanted_mask = with_bit(wanted_mask, opt, positive);
            emit_byte(tono_pkg::CH_LINK, tono_pkg::B_IAC);
            emit_byte(tono_pkg::CH_LINK, cmd);
            emit_byte(tono_pkg::CH_LINK, opt);
        end
    endfunction

    function automatic void predict_receive(logic [7:0] b, logic sup);
        t_parse_mode mode;
        mode = parse_mode;
        parse_mode = PM_DATA;
        case (mode)
            PM_IAC: begin
                if (b == tono_pkg::B_IAC) begin
                    if (!sup)
                        emit_byte(tono_pkg::CH_HOST, b);
                end else if (b == tono_pkg::B_DONT) begin
                    parse_mode = PM_DONT;
                end else if (b == tono_pkg::B_DO) begin
                    parse_mode = PM_DO;
                end else if (b == tono_pkg::B_WONT) begin
                    parse_mode = PM_WONT;
                end else if (b == tono_pkg::B_WILL) begin
                    parse_mode = PM_WILL;
                end else if (b == tono_pkg::B_SB || b == tono_pkg::B_SE) begin
                    parse_mode = PM_SKIP;
                end
            end
            PM_DONT: negotiate(tono_pkg::B_WONT, b);
            PM_DO:   negotiate(is_accepted(b) ? tono_pkg::B_WILL : tono_pkg::B_WONT, b);
            PM_WONT: negotiate(tono_pkg::B_DONT, b);
            PM_WILL: negotiate(is_accepted(b) ? tono_pkg::B_DO : tono_pkg::B_DONT, b);
            PM_SKIP: ;
            default: begin
                if (b == tono_pkg::B_IAC)
                    parse_mode = PM_IAC;
                else if (!sup)
                    emit_byte(tono_pkg::CH_HOST, b);
            end
        endcase
    endfunction

    function automatic void predict_transmit(logic [7:0] b);
        if (cr_pending) begin
            cr_pending = 1'b0;
            if (b != tono_pkg::B_LF)
                emit_byte(tono_pkg::CH_LINK, tono_pkg::B_NUL);
        end
        emit_byte(tono_pkg::CH_LINK, b);
        if (b == tono_pkg::B_IAC)
            emit_byte(tono_pkg::CH_LINK, b);
        else if (b == tono_pkg::B_CR)
            cr_pending = 1'b1;
    endfunction

    function automatic void predict_item(logic [1:0] op, logic [7:0] b, logic sup,
                                         logic [4:0] opt);
        int start;
        start = expected_bytes.size();
        case (op)
            tono_pkg::OP_RECV: predict_receive(b, sup);
            tono_pkg::OP_XMIT: predict_transmit(b);
            tono_pkg::OP_OFFER: begin
                if (opt < NUM_OPT && bit_of(wanted_mask, opt) && !bit_of(tried_mask, opt)) begin
                    tried_mask = with_bit(tried_mask, opt, 1'b1);
                    emit_byte(tono_pkg::CH_LINK, tono_pkg::B_IAC);
                    emit_byte(tono_pkg::CH_LINK, tono_pkg::B_WILL);
                    emit_byte(tono_pkg::CH_LINK, {3'b000, opt});
                end
            end
            default: ;
        endcase
        if (expected_bytes.size() > start)
            expected_bytes[expected_bytes.size() - 1].last = 1'b1;
    endfunction

    task automatic send_item(logic [1:0] op, logic [7:0] b, logic sup, logic [4:0] opt);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_chan.valid         <= 1'b0;
            in_chan.op            <= 2'($urandom);
            in_chan.data_byte     <= 8'($urandom);
            in_chan.suppress_data <= 1'($urandom);
            in_chan.option_index  <= 5'($urandom);
            @(negedge i_clk);
        end
        in_chan.valid         <= 1'b1;
        in_chan.op            <= op;
        in_chan.data_byte     <= b;
        in_chan.suppress_data <= sup;
        in_chan.option_index  <= opt;
        @(posedge i_clk);
        while (!in_chan.ready)
            @(posedge i_clk);
        predict_item(op, b, sup, opt);
    endtask

    task automatic recv_byte(logic [7:0] b, logic sup = 1'b0);
        send_item(tono_pkg::OP_RECV, b, sup, 5'($urandom));
    endtask

    task automatic xmit_byte(logic [7:0] b);
        send_item(tono_pkg::OP_XMIT, b, 1'($urandom), 5'($urandom));
    endtask

    task automatic wait_quiet();
        @(negedge i_clk);
        in_chan.valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_transfer(logic wr, logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= tono_pkg::APB_ADDR_W'(4 * tono_pkg::REG_ACCEPT_MASK_IDX);
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // read back, write, read back again
    task automatic set_accept_mask(logic [31:0] value);
        logic [31:0] rd;
        apb_transfer(1'b0, 32'd0, rd);
        if (rd !== accept_mask)
            note_mismatch("accept_mask read", accept_mask, rd);
        apb_transfer(1'b1, value, rd);
        accept_mask = value;
        apb_transfer(1'b0, 32'd0, rd);
        if (rd !== accept_mask)
            note_mismatch("accept_mask read", accept_mask, rd);
    endtask

    task automatic test_offers();
        send_item(tono_pkg::OP_OFFER, 8'($urandom), 1'b0, 5'd3);
        send_item(tono_pkg::OP_OFFER, 8'($urandom), 1'b1, 5'd0);
        send_item(tono_pkg::OP_OFFER, 8'($urandom), 1'b0, 5'd0);
        send_item(tono_pkg::OP_OFFER, 8'($urandom), 1'b0, 5'd31);
        send_item(OP_NONE, 8'hFF, 1'b1, 5'd31);
    endtask

    task automatic test_receive_path();
        recv_byte(8'h00);
        recv_byte(8'h7F, 1'b1);
        recv_byte(tono_pkg::B_IAC);
        recv_byte(tono_pkg::B_IAC, 1'b1);
    endtask

    task automatic test_negotiation();
        recv_byte(tono_pkg::B_IAC);
        recv_byte(tono_pkg::B_DO);
        recv_byte(8'd0);
        recv_byte(tono_pkg::B_IAC);
        recv_byte(tono_pkg::B_WILL);
        recv_byte(8'd5);
        // no option bits above the map, so always answered
        recv_byte(tono_pkg::B_IAC);
        recv_byte(tono_pkg::B_DONT, 1'b1);
        recv_byte(8'd200);
    endtask

    task automatic test_subnegotiation();
        recv_byte(tono_pkg::B_IAC);
        recv_byte(tono_pkg::B_SB);
        recv_byte(tono_pkg::B_IAC);
        recv_byte(tono_pkg::B_IAC);
        recv_byte(B_AYT);
    endtask

    task automatic test_transmit();
        xmit_byte(tono_pkg::B_CR);
        xmit_byte(8'h41);
        xmit_byte(tono_pkg::B_CR);
        xmit_byte(tono_pkg::B_LF);
        xmit_byte(tono_pkg::B_IAC);
        xmit_byte(8'h00);
    endtask

    task automatic test_random_traffic(int target, int send_pct, int recv_pct,
                                       logic [31:0] mask);
        int         sent;
        int         kind;
        logic       sup;
        logic [7:0] cmd;
        logic [7:0] b;
        wait_quiet();
        set_accept_mask(mask);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < target) begin
            kind = $urandom_range(0, 99);
            sup  = ($urandom_range(0, 3) == 0);
            if (kind < 30) begin
                case ($urandom_range(0, 3))
                    0:       cmd = tono_pkg::B_DO;
                    1:       cmd = tono_pkg::B_DONT;
                    2:       cmd = tono_pkg::B_WILL;
                    default: cmd = tono_pkg::B_WONT;
                endcase
                b = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 33));
                recv_byte(tono_pkg::B_IAC, sup);
                recv_byte(cmd, sup);
                recv_byte(b, sup);
                sent += 3;
            end else if (kind < 45) begin
                b = 8'($urandom);
                recv_byte(b, sup);
                sent++;
                if (b == tono_pkg::B_IAC) begin
                    recv_byte(tono_pkg::B_IAC, sup);
                    sent++;
                end
            end else if (kind < 70) begin
                case ($urandom_range(0, 4))
                    0:       b = tono_pkg::B_CR;
                    1:       b = tono_pkg::B_LF;
                    2:       b = tono_pkg::B_IAC;
                    default: b = 8'($urandom);
                endcase
                xmit_byte(b);
                sent++;
            end else if (kind < 78) begin
                send_item(tono_pkg::OP_OFFER, 8'($urandom), sup, 5'($urandom));
                sent++;
            end else if (kind < 85) begin
                recv_byte(tono_pkg::B_IAC, sup);
                recv_byte(($urandom_range(0, 1) == 0) ? tono_pkg::B_SB : tono_pkg::B_SE, sup);
                recv_byte(8'($urandom), sup);
                sent += 3;
            end else begin
                send_item(2'($urandom), 8'($urandom), sup, 5'($urandom));
                if (in_chan.op != OP_NONE)
                    sent++;
            end
        end
    endtask

    initial begin
        i_rst_n               = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        in_chan.valid         = 1'b0;
        in_chan.op            = tono_pkg::OP_RECV;
        in_chan.data_byte     = 8'h00;
        in_chan.suppress_data = 1'b0;
        in_chan.option_index  = 5'd0;

        accept_mask  = tono_pkg::ACCEPT_MASK_RST;
        parse_mode   = PM_DATA;
        cr_pending   = 1'b0;
        wanted_mask  = 64'h9;
        tried_mask   = '0;
        offered_mask = '0;
        agreed_mask  = '0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_offers();
        test_receive_path();
        test_negotiation();
        test_subnegotiation();
        test_transmit();
        test_random_traffic(45, 32, 81, 32'h0000_0000);
        test_random_traffic(45, 81, 32, 32'hFFFF_FFFF);
        test_random_traffic(41, 0, 0, $urandom());
        test_random_traffic(10, 0, 0, tono_pkg::ACCEPT_MASK_RST);

        wait_quiet();
        repeat (10) @(posedge i_clk);
        if (error_count == 0 && expected_bytes.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/tono_pkg.sv
rtl/tono_in_if.sv
rtl/tono_out_if.sv
rtl/tono_cfg.sv
rtl/tono_engine.sv
rtl/tono_outq.sv
rtl/telnet_option_negotiator_top.sv
verif/tb_telnet_option_negotiator_top.sv
